// ----- rtl/acsh_pkg.sv -----
// acsh_pkg: shared types, codes, tag tables and width helpers for the codec
// setup header checker. No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package acsh_pkg;

	// Default size limit of a setup blob in bytes
	localparam int MAX_BLOB_BYTES_DEF = 4096;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CODEC    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'b1;

	// Vorbis header kinds
	localparam logic [7:0] KIND_IDENT   = 8'd1;
	localparam logic [7:0] KIND_COMMENT = 8'd3;
	localparam logic [7:0] KIND_SETUP   = 8'd5;

	// Lacing and header layout constants
	localparam logic [7:0] LACE_CONT   = 8'd255;
	localparam logic [7:0] COUNT_BYTE  = 8'd2;
	localparam int         OPUS_MIN    = 19;
	localparam int         IDENT_MIN   = 16;
	localparam int         TAGGED_MIN  = 7;
	localparam int         CHAN_OFS    = 11;

	typedef enum logic [1:0] {
		VERDICT_VALID     = 2'd0,
		VERDICT_INVALID   = 2'd1,
		VERDICT_TRUNCATED = 2'd2,
		VERDICT_ZERO_RATE = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		PH_COUNT = 2'd0,
		PH_LACE0 = 2'd1,
		PH_LACE1 = 2'd2,
		PH_BODY  = 2'd3
	} phase_t;

	// Parse phase and sticky flags of the blob in flight
	typedef struct packed {
		phase_t phase;
		logic   invalid;
		logic   mismatch;
		logic   rate_nz;
	} acsh_flags_t;

	// Largest value a laced length can reach for a given size limit
	function automatic int lace_max(input int m);
		return (m >= 255) ? m + 254 : m * 255;
	endfunction

	// Width of offset sums (third header start plus a small margin)
	function automatic int sum_w(input int m);
		return $clog2(m + 2 * lace_max(m) + 20);
	endfunction

	// "OpusHead"
	function automatic logic [7:0] opus_magic_byte(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0:    c = 8'h4F;
			3'd1:    c = 8'h70;
			3'd2:    c = 8'h75;
			3'd3:    c = 8'h73;
			3'd4:    c = 8'h48;
			3'd5:    c = 8'h65;
			3'd6:    c = 8'h61;
			default: c = 8'h64;
		endcase
		return c;
	endfunction

	// "vorbis", indexed from 1 (byte after the kind byte)
	function automatic logic [7:0] vorbis_tag_byte(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd1:    c = 8'h76;
			3'd2:    c = 8'h6F;
			3'd3:    c = 8'h72;
			3'd4:    c = 8'h62;
			3'd5:    c = 8'h69;
			3'd6:    c = 8'h73;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/acsh_byte_check.sv -----
// acsh_byte_check: per-byte parse state of the setup blob (position, lacing,
// header offsets, sticky flags). Depends on acsh_pkg.
`timescale 1ns / 1ps

module acsh_byte_check import acsh_pkg::*; #(
	parameter int MAX_BLOB_BYTES = MAX_BLOB_BYTES_DEF,
	localparam int POS_W = $clog2(MAX_BLOB_BYTES + 2),
	localparam int LEN_W = $clog2(lace_max(MAX_BLOB_BYTES) + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        blob_byte,
	input  logic              final_byte,
	input  logic              codec_is_vorbis,
	input  logic [1:0]        expected_channels,
	output logic [POS_W-1:0]  pos_nxt,
	output logic [POS_W-1:0]  off_nxt,
	output logic [LEN_W-1:0]  len0_nxt,
	output logic [LEN_W-1:0]  len1_nxt,
	output acsh_flags_t       flags_nxt
);

	localparam int SUM_W = sum_w(MAX_BLOB_BYTES);
	localparam logic [SUM_W-1:0] MAX_S = SUM_W'(MAX_BLOB_BYTES);
	localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_BLOB_BYTES);
	localparam bit LACE_CAP = (MAX_BLOB_BYTES >= 255);
	localparam logic [LEN_W-1:0] LACE_LIMIT = LACE_CAP ? LEN_W'(MAX_BLOB_BYTES - 255) : '0;

	logic [POS_W-1:0] pos_q, off_q;
	logic [LEN_W-1:0] len0_q, len1_q;
	acsh_flags_t      flags_q;

	logic [SUM_W-1:0] pos_w, off_w, sec_w, third_w;
	logic [LEN_W-1:0] len_sel, len_add255, len_addb;
	logic             sat;

	// Byte of a header that must start with its kind and the vorbis tag
	function automatic logic tag_miss(input logic [SUM_W-1:0] pos, input logic [SUM_W-1:0] start,
			input logic [7:0] kind, input logic [7:0] b);
		logic [SUM_W-1:0] rel;
		logic             miss;
		rel  = pos - start;
		miss = 1'b0;
		if (pos >= start) begin
			if (rel == '0)
				miss = (b != kind);
			else if (rel < SUM_W'(TAGGED_MIN))
				miss = (b != vorbis_tag_byte(rel[2:0]));
		end
		return miss;
	endfunction

	assign pos_w      = SUM_W'(pos_q);
	assign off_w      = SUM_W'(off_q);
	assign sec_w      = off_w + SUM_W'(len0_q);
	assign third_w    = sec_w + SUM_W'(len1_q);
	assign sat        = pos_w >= MAX_S;
	assign len_sel    = (flags_q.phase == PH_LACE0) ? len0_q : len1_q;
	assign len_add255 = len_sel + LEN_W'(LACE_CONT);
	assign len_addb   = len_sel + LEN_W'(blob_byte);

	// Next state for the word in the input stage
	always_comb begin
		pos_nxt   = (pos_q <= MAX_P) ? pos_q + POS_W'(1) : pos_q;
		off_nxt   = off_q;
		len0_nxt  = len0_q;
		len1_nxt  = len1_q;
		flags_nxt = flags_q;
		if (sat) begin
			flags_nxt.invalid = 1'b1;
		end else if (codec_is_vorbis) begin
			case (flags_q.phase)
				PH_COUNT: begin
					if (blob_byte != COUNT_BYTE)
						flags_nxt.invalid = 1'b1;
					flags_nxt.phase = PH_LACE0;
				end
				PH_LACE0, PH_LACE1: begin
					if (blob_byte == LACE_CONT) begin
						if (LACE_CAP && (len_sel > LACE_LIMIT))
							flags_nxt.invalid = 1'b1;
						else if (flags_q.phase == PH_LACE0)
							len0_nxt = len_add255;
						else
							len1_nxt = len_add255;
					end else if (flags_q.phase == PH_LACE0) begin
						len0_nxt        = len_addb;
						flags_nxt.phase = PH_LACE1;
					end else begin
						len1_nxt        = len_addb;
						flags_nxt.phase = PH_BODY;
						off_nxt         = pos_q + POS_W'(1);
					end
				end
				PH_BODY: begin
					if (tag_miss(pos_w, off_w, KIND_IDENT, blob_byte) ||
							tag_miss(pos_w, sec_w, KIND_COMMENT, blob_byte) ||
							tag_miss(pos_w, third_w, KIND_SETUP, blob_byte) ||
							((pos_w == off_w + SUM_W'(CHAN_OFS)) &&
							 (blob_byte != {6'b0, expected_channels})))
						flags_nxt.mismatch = 1'b1;
					if ((pos_w >= off_w + SUM_W'(12)) && (pos_w <= off_w + SUM_W'(15)) &&
							(blob_byte != 8'd0))
						flags_nxt.rate_nz = 1'b1;
				end
				default: ;
			endcase
		end else begin
			// Opus head: magic, channel count, mapping family zero
			if (pos_q < POS_W'(8)) begin
				if (blob_byte != opus_magic_byte(pos_q[2:0]))
					flags_nxt.mismatch = 1'b1;
			end else if (pos_q == POS_W'(9)) begin
				if (blob_byte != {6'b0, expected_channels})
					flags_nxt.mismatch = 1'b1;
			end else if (pos_q == POS_W'(OPUS_MIN - 1)) begin
				if (blob_byte != 8'd0)
					flags_nxt.mismatch = 1'b1;
			end
		end
	end

	// State registers; cleared after the final word of a blob
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			off_q   <= '0;
			len0_q  <= '0;
			len1_q  <= '0;
			flags_q <= '{phase: PH_COUNT, invalid: 1'b0, mismatch: 1'b0, rate_nz: 1'b0};
		end else if (step) begin
			if (final_byte) begin
				pos_q   <= '0;
				off_q   <= '0;
				len0_q  <= '0;
				len1_q  <= '0;
				flags_q <= '{phase: PH_COUNT, invalid: 1'b0, mismatch: 1'b0, rate_nz: 1'b0};
			end else begin
				pos_q   <= pos_nxt;
				off_q   <= off_nxt;
				len0_q  <= len0_nxt;
				len1_q  <= len1_nxt;
				flags_q <= flags_nxt;
			end
		end
	end

endmodule

// ----- rtl/acsh_verdict.sv -----
// acsh_verdict: verdict of a finished blob from its final parse state.
// Depends on acsh_pkg.
`timescale 1ns / 1ps

module acsh_verdict import acsh_pkg::*; #(
	parameter int MAX_BLOB_BYTES = MAX_BLOB_BYTES_DEF,
	localparam int POS_W = $clog2(MAX_BLOB_BYTES + 2),
	localparam int LEN_W = $clog2(lace_max(MAX_BLOB_BYTES) + 1)
) (
	input  logic             codec_is_vorbis,
	input  logic [POS_W-1:0] size,
	input  logic [POS_W-1:0] first_header_offset,
	input  logic [LEN_W-1:0] first_header_length,
	input  logic [LEN_W-1:0] second_header_length,
	input  acsh_flags_t      flags,
	output verdict_t         verdict
);

	localparam int SUM_W = sum_w(MAX_BLOB_BYTES);

	logic [SUM_W-1:0] size_w, at_w, len0_w, len1_w, sec_w, third_w;

	assign size_w  = SUM_W'(size);
	assign at_w    = SUM_W'(first_header_offset);
	assign len0_w  = SUM_W'(first_header_length);
	assign len1_w  = SUM_W'(second_header_length);
	assign sec_w   = at_w + len0_w;
	assign third_w = sec_w + len1_w;

	// Priority (Vorbis): invalid, truncated, header checks, zero sample rate; Opus: valid or invalid
	always_comb begin
		verdict = VERDICT_VALID;
		if (!codec_is_vorbis) begin
			if (flags.invalid || flags.mismatch || (size_w < SUM_W'(OPUS_MIN)))
				verdict = VERDICT_INVALID;
		end else if (flags.invalid || (flags.phase != PH_BODY)) begin
			verdict = VERDICT_INVALID;
		end else if ((at_w > size_w) || (len0_w > size_w - at_w) ||
				(len1_w > size_w - sec_w)) begin
			verdict = VERDICT_TRUNCATED;
		end else if (flags.mismatch || (len0_w < SUM_W'(IDENT_MIN)) ||
				(len1_w < SUM_W'(TAGGED_MIN)) ||
				(size_w - third_w < SUM_W'(TAGGED_MIN))) begin
			verdict = VERDICT_INVALID;
		end else if (!flags.rate_nz) begin
			verdict = VERDICT_ZERO_RATE;
		end
	end

endmodule

// ----- rtl/audio_codec_setup_header_checker_core.sv -----
// audio_codec_setup_header_checker_core: top level of the setup blob checker,
// with input stage, output register and configuration registers.
// Depends on acsh_pkg, acsh_byte_check and acsh_verdict.
`timescale 1ns / 1ps

// Usage
//   Slave stream s_*: one blob byte per word in s_tdata, s_tlast on the last
//   byte of a blob. Master stream m_*: one verdict word per blob, sent for its
//   last byte (0 valid, 1 invalid, 2 truncated, 3 zero sample rate).
//   Config port: cfg_we with cfg_index 0 (codec_is_vorbis) or 1
//   (expected_channels); write only while no blob is in flight.
// Timing
//   A byte is registered in the input stage on acceptance; as it leaves, it
//   updates the parse state and a last byte loads its verdict into the output
//   register. One byte is taken per cycle unless a last byte waits on a
//   verdict; the byte stage and per-byte compare and lacing adders set it.
// Stall
//   Bytes that end no blob keep flowing while a verdict waits. A last byte
//   that meets a verdict not yet taken waits in the input stage, and only then
//   does s_tready drop.
// Reset
//   arst_n clears the parse state, the stages and the registers (Opus mode,
//   two channels); the block takes words right after reset.

module audio_codec_setup_header_checker_core import acsh_pkg::*; #(
	parameter int MAX_BLOB_BYTES = MAX_BLOB_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// blob byte stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] blob_byte
	input  logic                 s_tlast,   // final_byte
	// verdict stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [1:0] verdict, [7:2] zero
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [1:0]           cfg_data
);

	localparam int POS_W = $clog2(MAX_BLOB_BYTES + 2);
	localparam int LEN_W = $clog2(lace_max(MAX_BLOB_BYTES) + 1);

	logic             codec_q;
	logic [1:0]       chan_q;
	logic             valid_s1, last_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	verdict_t         verdict_q, verdict_c;
	logic             advance;

	logic [POS_W-1:0] pos_nxt, off_nxt;
	logic [LEN_W-1:0] len0_nxt, len1_nxt;
	acsh_flags_t      flags_nxt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= 1'b0;
			chan_q  <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CODEC:    codec_q <= cfg_data[0];
				CFG_CHANNELS: chan_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage moves on unless a final word meets a waiting verdict
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	acsh_byte_check #(
		.MAX_BLOB_BYTES(MAX_BLOB_BYTES)
	) u_byte_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.blob_byte        (byte_s1),
		.final_byte       (last_s1),
		.codec_is_vorbis  (codec_q),
		.expected_channels(chan_q),
		.pos_nxt          (pos_nxt),
		.off_nxt          (off_nxt),
		.len0_nxt         (len0_nxt),
		.len1_nxt         (len1_nxt),
		.flags_nxt        (flags_nxt)
	);

	acsh_verdict #(
		.MAX_BLOB_BYTES(MAX_BLOB_BYTES)
	) u_verdict (
		.codec_is_vorbis     (codec_q),
		.size                (pos_nxt),
		.first_header_offset (off_nxt),
		.first_header_length (len0_nxt),
		.second_header_length(len1_nxt),
		.flags               (flags_nxt),
		.verdict             (verdict_c)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && last_s1)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			verdict_q <= verdict_c;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, verdict_q};

	// A final word that leaves the input stage always yields a verdict
	a_final_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> m_tvalid)
		else $error("final word left no verdict");

	// Input back-pressure only from a final word blocked by a waiting verdict
	a_ready_only_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && last_s1 && out_valid_q && !m_tready)
		else $error("input stalled without a blocked verdict");

	// Upper bits of the verdict word stay zero
	a_verdict_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:2] == 6'b0)
		else $error("verdict padding not zero");

endmodule
